// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the array list engine RTL.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge out of reset.
`define ALE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a trigger implies a condition in the same cycle.
`define ALE_ASSERT_IMPL(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);
`else
`define ALE_ASSERT(lbl, prop, msg)
`define ALE_ASSERT_IMPL(lbl, trig, cond, msg)
`endif
`endif

// ===== rtl/alist_pkg.sv =====
// Package for the array list engine: opcodes, status codes, states and cell control.
// Depends on nothing.
package alist_pkg;

    typedef enum logic [3:0] {
        OP_CLEAR   = 4'd0,
        OP_APPEND  = 4'd1,
        OP_SHOW    = 4'd2,
        OP_INSERT  = 4'd3,
        OP_DELETE  = 4'd4,
        OP_SEARCH  = 4'd5,
        OP_SORT    = 4'd6,
        OP_REVERSE = 4'd7,
        OP_MINMAX  = 4'd8,
        OP_SUM     = 4'd9
    } op_t;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_EMPTY    = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_BADPOS   = 3'd3;
    localparam logic [2:0] STS_NOTFOUND = 3'd4;
    localparam logic [2:0] STS_BADOP    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_REV,
        ST_WALK,
        ST_FIN
    } fsm_t;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_WRITE,
        CM_INSERT,
        CM_DELETE,
        CM_ROT,
        CM_SORT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t  mode;
        logic [6:0]  lim;
        logic [6:0]  pos;
        logic        phase;
    } cell_ctrl_t;

endpackage

// ===== rtl/alist_cell.sv =====
// One storage cell of the list chain; holds one entry and trades with its neighbors.
// Depends on alist_pkg.
module alist_cell
    import alist_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic signed [31:0] operand,
    input  logic signed [31:0] left_q,
    input  logic signed [31:0] right_q,
    input  logic signed [31:0] head_q,
    output logic signed [31:0] q
);

    localparam logic [6:0] ID = 7'(IDX);

    logic signed [31:0] q_reg;
    logic signed [31:0] q_next;

    // Choose the next entry from the command shared by the whole chain.
    always_comb
    begin
        q_next = q_reg;
        unique case (ctrl.mode)
            CM_WRITE:
            begin
                if (ID == ctrl.pos)
                    q_next = operand;
            end
            CM_INSERT:
            begin
                if (ID > ctrl.pos)
                    q_next = left_q;
                else if (ID == ctrl.pos)
                    q_next = operand;
            end
            CM_DELETE:
            begin
                if (ID >= ctrl.pos)
                    q_next = right_q;
            end
            CM_ROT:
            begin
                if ((ID + 7'd1) < ctrl.lim)
                    q_next = right_q;
                else if ((ID + 7'd1) == ctrl.lim)
                    q_next = head_q;
            end
            CM_SORT:
            begin
                // Left member of a pair keeps the smaller, right member the larger.
                if ((ID[0] == ctrl.phase) && ((ID + 7'd1) < ctrl.lim))
                begin
                    if (right_q < q_reg)
                        q_next = right_q;
                end
                else if ((ID != 7'd0) && (ID[0] != ctrl.phase) && (ID < ctrl.lim))
                begin
                    if (left_q > q_reg)
                        q_next = left_q;
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== rtl/array_list_engine.sv =====
// Array list engine: an ordered list of signed 32-bit entries held in a chain of cells.
// A request enters on s_tdata: opcode [3:0], position [10:4], operand [42:11].
// Results leave on m_tdata: status [2:0], value [40:3], second_value [72:41],
// index [78:73], size [85:79]; m_tlast marks the final result of a request.
// Clear, append, insert and immediate errors answer straight from the idle state.
// Show, search, min/max, sum and delete walk the list by rotating the chain one
// place per cycle while a result can be written; search, min/max, sum and
// delete then give their final result from the finishing state.
// Sort runs entry_count odd-even phases in the chain, reverse runs entry_count
// prefix rotations; both are then followed by a show walk.
// A new request is taken only when the engine is idle and the output register
// is free or being emptied. A stalled receiver holds the walk in place: the
// chain rotates only when a result can be written.
// Reset empties the list at once; entry contents are not cleared.
// Depends on alist_pkg, alist_cell and assert_macros.svh.
`include "assert_macros.svh"
module array_list_engine
    import alist_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode, position, operand, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // status, value, second_value, index, size, zero pad
    output logic        m_tlast
);

    localparam logic [6:0] DEPTH_C = 7'(DEPTH);

    fsm_t state_reg, state_next;
    logic [6:0]  count_reg, count_next;
    logic [6:0]  k_reg, k_next;
    op_t         op_reg, op_next;
    logic [6:0]  pos_reg, pos_next;
    logic signed [31:0] key_reg, key_next;
    logic        pend_reg, pend_next;
    logic [5:0]  pidx_reg, pidx_next;
    logic signed [37:0] acc_reg, acc_next;
    logic signed [31:0] mx_reg, mx_next;
    logic signed [31:0] gone_reg, gone_next;
    logic        ov_reg, ov_next;
    logic [2:0]  o_sts_reg;
    logic [37:0] o_val_reg;
    logic [31:0] o_sec_reg;
    logic [5:0]  o_idx_reg;
    logic [6:0]  o_size_reg;
    logic        o_last_reg;

    logic        slot_free, accept, emit, e_last, is_last_k;
    logic [2:0]  e_sts;
    logic [37:0] e_val;
    logic [31:0] e_sec;
    logic [5:0]  e_idx;
    op_t         in_op;
    logic [6:0]  in_pos;
    logic signed [31:0] in_opnd;
    cell_ctrl_t  ctrl;
    logic signed [31:0] q [DEPTH];
    logic signed [31:0] head;
    logic signed [37:0] head_ext;

    assign in_op     = op_t'(s_tdata[3:0]);
    assign in_pos    = s_tdata[10:4];
    assign in_opnd   = s_tdata[42:11];
    assign head      = q[0];
    assign head_ext  = {{6{head[31]}}, head};
    assign slot_free = !ov_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign is_last_k = (k_reg + 7'd1) == count_reg;

    // Chain of entry cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        alist_cell #(.IDX(i)) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .operand (state_reg == ST_IDLE ? in_opnd : key_reg),
            .left_q  (q[(i == 0) ? 0 : i - 1]),
            .right_q (q[(i == DEPTH - 1) ? i : i + 1]),
            .head_q  (head),
            .q       (q[i])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && count_reg != 7'd0)
                begin
                    case (in_op) inside
                        OP_SHOW, OP_SEARCH, OP_MINMAX, OP_SUM: state_next = ST_WALK;
                        OP_DELETE: state_next = (in_pos < count_reg) ? ST_WALK : ST_IDLE;
                        OP_SORT:    state_next = ST_SORT;
                        OP_REVERSE: state_next = ST_REV;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SORT, ST_REV:
            begin
                if (is_last_k)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (slot_free && is_last_k)
                begin
                    case (op_reg) inside
                        OP_SEARCH, OP_MINMAX, OP_SUM, OP_DELETE: state_next = ST_FIN;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and result selection.
    always_comb
    begin
        count_next = count_reg;
        k_next     = k_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        acc_next   = acc_reg;
        mx_next    = mx_reg;
        gone_next  = gone_reg;
        ctrl       = '{mode: CM_HOLD, lim: count_reg, pos: pos_reg, phase: 1'b0};
        emit       = 1'b0;
        e_sts      = STS_OK;
        e_val      = '0;
        e_sec      = '0;
        e_idx      = '0;
        e_last     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = in_op;
                    pos_next  = in_pos;
                    key_next  = in_opnd;
                    pend_next = 1'b0;
                    k_next    = 7'd0;
                    emit      = 1'b1;
                    case (in_op) inside
                        OP_CLEAR:
                        begin
                            count_next = 7'd0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg >= DEPTH_C)
                                e_sts = STS_FULL;
                            else
                            begin
                                ctrl.mode  = CM_WRITE;
                                ctrl.pos   = count_reg;
                                count_next = count_reg + 7'd1;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (count_reg >= DEPTH_C)
                                e_sts = STS_FULL;
                            else if (in_pos > count_reg)
                                e_sts = STS_BADPOS;
                            else
                            begin
                                ctrl.mode  = CM_INSERT;
                                ctrl.pos   = in_pos;
                                count_next = count_reg + 7'd1;
                            end
                        end
                        OP_SHOW, OP_DELETE, OP_SEARCH, OP_SORT, OP_REVERSE, OP_MINMAX,
                        OP_SUM:
                        begin
                            if (count_reg == 7'd0)
                                e_sts = STS_EMPTY;
                            else if (in_op == OP_DELETE && in_pos >= count_reg)
                                e_sts = STS_BADPOS;
                            else
                                emit = 1'b0;
                        end
                        default:
                        begin
                            e_sts = STS_BADOP;
                        end
                    endcase
                end
            end
            ST_SORT:
            begin
                ctrl.mode  = CM_SORT;
                ctrl.phase = k_reg[0];
                k_next     = is_last_k ? 7'd0 : k_reg + 7'd1;
            end
            ST_REV:
            begin
                ctrl.mode = CM_ROT;
                ctrl.lim  = count_reg - k_reg;
                k_next    = is_last_k ? 7'd0 : k_reg + 7'd1;
            end
            ST_WALK:
            begin
                if (slot_free)
                begin
                    ctrl.mode = CM_ROT;
                    k_next    = k_reg + 7'd1;
                    case (op_reg)
                        OP_SEARCH:
                        begin
                            if (head == key_reg)
                            begin
                                // An earlier match goes out now that another one exists.
                                emit      = pend_reg;
                                e_val     = {{6{key_reg[31]}}, key_reg};
                                e_idx     = pidx_reg;
                                e_last    = 1'b0;
                                pend_next = 1'b1;
                                pidx_next = k_reg[5:0];
                            end
                        end
                        OP_MINMAX:
                        begin
                            if (k_reg == 7'd0 || head_ext < acc_reg)
                                acc_next = head_ext;
                            if (k_reg == 7'd0 || head > mx_reg)
                                mx_next = head;
                        end
                        OP_SUM:
                        begin
                            acc_next = (k_reg == 7'd0) ? head_ext : acc_reg + head_ext;
                        end
                        OP_DELETE:
                        begin
                            if (k_reg == pos_reg)
                                gone_next = head;
                        end
                        default:
                        begin
                            emit   = 1'b1;
                            e_val  = head_ext;
                            e_idx  = k_reg[5:0];
                            e_last = is_last_k;
                        end
                    endcase
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    case (op_reg)
                        OP_SEARCH:
                        begin
                            if (pend_reg)
                            begin
                                e_val = {{6{key_reg[31]}}, key_reg};
                                e_idx = pidx_reg;
                            end
                            else
                                e_sts = STS_NOTFOUND;
                        end
                        OP_MINMAX:
                        begin
                            e_val = acc_reg;
                            e_sec = mx_reg;
                        end
                        OP_SUM:
                        begin
                            e_val = acc_reg;
                        end
                        default:
                        begin
                            ctrl.mode  = CM_DELETE;
                            count_next = count_reg - 7'd1;
                            e_val      = {{6{gone_reg[31]}}, gone_reg};
                        end
                    endcase
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        ov_next = emit || (ov_reg && !m_tready);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 7'd0;
            k_reg     <= 7'd0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        pidx_reg <= pidx_next;
        acc_reg  <= acc_next;
        mx_reg   <= mx_next;
        gone_reg <= gone_next;
        if (emit)
        begin
            o_sts_reg  <= e_sts;
            o_val_reg  <= e_val;
            o_sec_reg  <= e_sec;
            o_idx_reg  <= e_idx;
            o_size_reg <= count_next;
            o_last_reg <= e_last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, o_size_reg, o_idx_reg, o_sec_reg, o_val_reg, o_sts_reg};
    assign m_tlast  = o_last_reg;

    `ALE_ASSERT(a_count_range, count_reg <= DEPTH_C, "entry count exceeds depth")
    `ALE_ASSERT_IMPL(a_busy_nonempty, state_reg != ST_IDLE, count_reg != 7'd0,
        "engine busy on an empty list")
    `ALE_ASSERT_IMPL(a_step_range,
        state_reg == ST_WALK || state_reg == ST_SORT || state_reg == ST_REV,
        k_reg < count_reg, "step counter beyond list")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the array list engine: directed and random list requests.
// Depends on alist_pkg and the array_list_engine RTL.
`timescale 1ns / 1ps
module testbench;
    import alist_pkg::*;

    // One expected or observed result.
    typedef struct packed {
        logic [2:0]  status;
        logic [37:0] value;
        logic [31:0] second_value;
        logic [5:0]  index;
        logic [6:0]  size;
        logic        last;
    } result_t;

    // List model and the queue of results it predicts.
    class list_scoreboard;
        logic signed [31:0] cells[64];
        int unsigned        count;
        result_t            pending[$];
        int                 errors;
        int                 checked;

        function new();
            count = 0;
            errors = 0;
            checked = 0;
        endfunction

        // Prints one mismatch line and counts it.
        task report_error(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        function void push(logic [2:0] st, logic [37:0] v, logic [31:0] sv,
                           logic [5:0] ix, logic lst);
            result_t r;
            r.status = st;
            r.value = v;
            r.second_value = sv;
            r.index = ix;
            r.size = count[6:0];
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void push_show();
            for (int i = 0; i < count; i++)
                push(STS_OK, 38'(cells[i]), '0, 6'(i), i + 1 == count);
        endfunction

        // Applies one accepted request to the list and queues its results.
        function void note_request(logic [3:0] op, logic [6:0] pos,
                                   logic signed [31:0] opnd);
            logic signed [31:0] t;
            logic signed [31:0] mn;
            logic signed [31:0] mx;
            logic signed [37:0] acc;
            int lastm;
            if (op > OP_SUM) begin
                push(STS_BADOP, '0, '0, '0, 1'b1);
                return;
            end
            if (op == OP_CLEAR) begin
                count = 0;
                push(STS_OK, '0, '0, '0, 1'b1);
                return;
            end
            if (op == OP_APPEND || op == OP_INSERT) begin
                if (count >= 64) push(STS_FULL, '0, '0, '0, 1'b1);
                else if (op == OP_INSERT && pos > count)
                    push(STS_BADPOS, '0, '0, '0, 1'b1);
                else begin
                    if (op == OP_APPEND) cells[count] = opnd;
                    else begin
                        for (int i = count; i > pos; i--) cells[i] = cells[i - 1];
                        cells[pos] = opnd;
                    end
                    count++;
                    push(STS_OK, '0, '0, '0, 1'b1);
                end
                return;
            end
            if (count == 0) begin
                push(STS_EMPTY, '0, '0, '0, 1'b1);
                return;
            end
            case (op)
                OP_SHOW: push_show();
                OP_DELETE:
                begin
                    if (pos >= count) push(STS_BADPOS, '0, '0, '0, 1'b1);
                    else begin
                        t = cells[pos];
                        for (int i = pos; i + 1 < count; i++) cells[i] = cells[i + 1];
                        count--;
                        push(STS_OK, 38'(t), '0, '0, 1'b1);
                    end
                end
                OP_SEARCH:
                begin
                    lastm = -1;
                    for (int i = 0; i < count; i++) if (cells[i] == opnd) lastm = i;
                    if (lastm < 0) push(STS_NOTFOUND, '0, '0, '0, 1'b1);
                    else
                        for (int i = 0; i < count; i++)
                            if (cells[i] == opnd)
                                push(STS_OK, 38'(cells[i]), '0, 6'(i), i == lastm);
                end
                OP_SORT:
                begin
                    for (int i = 0; i + 1 < count; i++)
                        for (int j = 0; j + 1 < count - i; j++)
                            if (cells[j] > cells[j + 1]) begin
                                t = cells[j];
                                cells[j] = cells[j + 1];
                                cells[j + 1] = t;
                            end
                    push_show();
                end
                OP_REVERSE:
                begin
                    for (int i = 0, j = count - 1; i < j; i++, j--) begin
                        t = cells[i];
                        cells[i] = cells[j];
                        cells[j] = t;
                    end
                    push_show();
                end
                OP_MINMAX:
                begin
                    mn = cells[0];
                    mx = cells[0];
                    for (int i = 1; i < count; i++) begin
                        if (cells[i] < mn) mn = cells[i];
                        if (cells[i] > mx) mx = cells[i];
                    end
                    push(STS_OK, 38'(mn), mx, '0, 1'b1);
                end
                default:
                begin
                    acc = '0;
                    for (int i = 0; i < count; i++) acc += 38'(cells[i]);
                    push(STS_OK, acc, '0, '0, 1'b1);
                end
            endcase
        endfunction

        // Compares one observed result with the oldest prediction.
        task check_result(result_t got);
            result_t want;
            checked++;
            if (pending.size() == 0) begin
                report_error($sformatf("unexpected result %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report_error($sformatf("status %0d want %0d", got.status, want.status));
            if (got.value !== want.value)
                report_error($sformatf("value %h want %h", got.value, want.value));
            if (got.second_value !== want.second_value)
                report_error($sformatf("second %h want %h", got.second_value,
                                       want.second_value));
            if (got.index !== want.index)
                report_error($sformatf("index %0d want %0d", got.index, want.index));
            if (got.size !== want.size)
                report_error($sformatf("size %0d want %0d", got.size, want.size));
            if (got.last !== want.last)
                report_error($sformatf("last %0b want %0b", got.last, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // opcode, position, operand, zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // status, value, second_value, index, size, zero pad
    logic        m_tlast;

    list_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;
    int requests;

    array_list_engine u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Receiver: random stalls, checks each accepted result.
    always @(posedge clk) begin
        result_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tdata[2:0];
            got.value = m_tdata[40:3];
            got.second_value = m_tdata[72:41];
            got.index = m_tdata[78:73];
            got.size = m_tdata[85:79];
            got.last = m_tlast;
            sb.check_result(got);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Timeout watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > 1500000) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL array_list_engine");
            $finish;
        end
    end

    // Sends one request, holding it until accepted.
    task automatic send_request(logic [3:0] op, logic [6:0] pos, logic [31:0] opnd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, opnd, pos, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(op, pos, opnd);
        requests++;
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    // Random request mix that keeps the list mostly populated.
    task automatic random_request();
        logic [3:0] op;
        logic [6:0] pos;
        int r;
        r = $urandom_range(99);
        if (r < 30) op = OP_APPEND;
        else if (r < 42) op = OP_INSERT;
        else if (r < 54) op = OP_DELETE;
        else if (r < 64) op = OP_SEARCH;
        else if (r < 70) op = OP_SHOW;
        else if (r < 75) op = OP_SORT;
        else if (r < 80) op = OP_REVERSE;
        else if (r < 86) op = OP_MINMAX;
        else if (r < 92) op = OP_SUM;
        else if (r < 95) op = OP_CLEAR;
        else op = 4'($urandom_range(15));
        if ($urandom_range(9) == 0) pos = 7'($urandom);
        else pos = 7'($urandom_range(sb.count + 1));
        if (op == OP_SEARCH && sb.count > 0 && $urandom_range(1))
            send_request(op, pos, sb.cells[$urandom_range(sb.count - 1)]);
        else
            send_request(op, pos, rand_operand());
    endtask

    initial begin
        sb = new();
        cycles = 0;
        requests = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list errors, extremes, bad positions, bad opcode.
        for (int op = OP_SHOW; op <= OP_SUM; op++)
            if (op != OP_INSERT) send_request(4'(op), 7'd0, 32'd5);
        send_request(OP_INSERT, 7'd1, 32'd1);
        send_request(OP_APPEND, 7'd0, 32'h8000_0000);
        send_request(OP_APPEND, 7'd0, 32'h7fff_ffff);
        send_request(OP_INSERT, 7'd1, 32'h7fff_ffff);
        send_request(OP_INSERT, 7'd0, 32'hffff_ffff);
        send_request(OP_SEARCH, 7'd0, 32'h7fff_ffff);
        send_request(OP_SEARCH, 7'd0, 32'd12345);
        send_request(OP_DELETE, 7'd4, 32'd0);
        send_request(OP_DELETE, 7'd127, 32'd0);
        send_request(OP_SORT, 7'd0, 32'd0);
        send_request(OP_REVERSE, 7'd0, 32'd0);
        send_request(OP_MINMAX, 7'd0, 32'd0);
        send_request(OP_DELETE, 7'd0, 32'd0);
        send_request(4'd10, 7'd0, 32'd0);
        send_request(4'd15, 7'h7f, 32'hffff_ffff);
        send_request(OP_CLEAR, 7'd0, 32'd0);
        // Fill the list with the most negative value to reach full and the sum extreme.
        for (int i = 0; i < 64; i++) send_request(OP_APPEND, 7'd0, 32'h8000_0000);
        send_request(OP_SUM, 7'd0, 32'd0);
        send_request(OP_APPEND, 7'd0, 32'd1);
        send_request(OP_INSERT, 7'd70, 32'd1);
        send_request(OP_SEARCH, 7'd0, 32'h8000_0000);
        send_request(OP_CLEAR, 7'd0, 32'd0);
        for (int i = 0; i < 64; i++) send_request(OP_APPEND, 7'd0, 32'h7fff_ffff);
        send_request(OP_SUM, 7'd0, 32'd0);
        send_request(OP_CLEAR, 7'd0, 32'd0);

        // Random phases with different idle and stall rates.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < 30; n++) random_request();
        end
        s_tvalid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // Drain outstanding results, then a short quiet period.
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Ran %0d requests and checked %0d results over all ops,", requests,
                 sb.checked);
        $display("with sender gaps and receiver stalls; %0d mismatches.", sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS array_list_engine");
        else
            $display("FAIL array_list_engine");
        $finish;
    end

endmodule
